// File: sv/lfps_pkg.sv
// Shared widths, constants and types of the line-follow PID steering unit
package lfps_pkg;

	// Stream field widths
	localparam int SAMPLE_W = 12;
	localparam int GAIN_W   = 16;
	localparam int POWER_W  = 8;
	localparam int DUTY_W   = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 2 * DUTY_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POWER      = 2'd3;
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd128;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd9;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd3584;
	localparam logic [POWER_W-1:0] POWER_RST      = 8'd70;

	// Error path
	localparam int WINDOW_DEF = 9;
	localparam int ERR_W      = 20;
	localparam int SUM_W      = 24;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int MIDP_W     = 27;
	localparam int MTERM_W    = 17;
	localparam int EPROD_W    = 32;
	localparam int E_FRAC     = 12;
	localparam int MID_COEF   = 19661;
	localparam int MTERM_BASE = 87818;

	// Controller output and duty
	localparam int U_W      = 42;
	localparam int ONE_Q24  = 1 << 24;
	localparam int NUM_W    = 49;
	localparam int QUO_W    = 17;
	localparam int DIVISOR  = 51200;
	localparam int DIV_HALF = 25600;
	localparam int DUTY_MID = 32768;

	// Digit-serial multiplier
	localparam int DIG_W     = 4;
	localparam int MUL_A_W   = U_W;
	localparam int MUL_B_W   = MTERM_W;
	localparam int MUL_ACC_W = MUL_A_W + MUL_B_W;
	localparam int NDIG_MAX  = (MUL_B_W + DIG_W - 1) / DIG_W;
	localparam int MUL_CNT_W = $clog2(NDIG_MAX + 1);
	localparam logic [MUL_CNT_W-1:0] NDIG_MID   = MUL_CNT_W'((SAMPLE_W + DIG_W - 1) / DIG_W);
	localparam logic [MUL_CNT_W-1:0] NDIG_MTERM = MUL_CNT_W'((MTERM_W + DIG_W - 1) / DIG_W);
	localparam logic [MUL_CNT_W-1:0] NDIG_GAIN  = MUL_CNT_W'((GAIN_W + DIG_W - 1) / DIG_W);
	localparam logic [MUL_CNT_W-1:0] NDIG_POWER = MUL_CNT_W'((POWER_W + DIG_W - 1) / DIG_W);

	// Command to the multiplier
	typedef struct packed {
		logic                 start;
		logic                 accum;
		logic [MUL_CNT_W-1:0] ndig;
	} mul_cmd_t;

endpackage

// File: sv/lfps_digit_mul.sv
// Signed by unsigned multiply-accumulate, one multiplier digit per cycle, LSB first
module lfps_digit_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lfps_pkg::mul_cmd_t                    cmd,
	input  logic signed [lfps_pkg::MUL_A_W-1:0]   a,
	input  logic        [lfps_pkg::MUL_B_W-1:0]   b,
	output logic                                  done,
	output logic signed [lfps_pkg::MUL_ACC_W-1:0] acc
);

	localparam int ACC_W = lfps_pkg::MUL_ACC_W;
	localparam int DIG_W = lfps_pkg::DIG_W;

	logic signed [ACC_W-1:0]              a_q;
	logic        [lfps_pkg::MUL_B_W-1:0]  b_q;
	logic signed [ACC_W-1:0]              acc_q;
	logic        [lfps_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                                 run_q;
	logic                                 done_q;
	logic signed [DIG_W:0]                dig_s;
	logic signed [ACC_W-1:0]              pp;

	// Partial product of the shifted multiplicand and the current digit
	assign dig_s = $signed({1'b0, b_q[DIG_W-1:0]});
	assign pp    = a_q * ACC_W'(dig_s);

	// Load, then advance one digit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				a_q   <= ACC_W'(a);
				b_q   <= b;
				cnt_q <= cmd.ndig;
				run_q <= 1'b1;
				if (!cmd.accum) begin
					acc_q <= '0;
				end
			end else if (run_q) begin
				acc_q <= acc_q + pp;
				a_q   <= a_q <<< DIG_W;
				b_q   <= b_q >> DIG_W;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lfps_pkg::MUL_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// File: sv/lfps_duty_div.sv
// Rounded division by the duty scale, one quotient bit per cycle, with saturation
module lfps_duty_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lfps_pkg::NUM_W-1:0]        num,
	input  logic                              neg,
	output logic                              done,
	output logic [lfps_pkg::DUTY_W-1:0]       duty
);

	localparam int NUM_W = lfps_pkg::NUM_W;
	localparam int QUO_W = lfps_pkg::QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 1);
	localparam logic [NUM_W-1:0] DIV_INIT = NUM_W'(lfps_pkg::DIVISOR) << (QUO_W - 1);
	localparam logic [NUM_W-1:0] SAT_LIM  = NUM_W'(lfps_pkg::DIVISOR) << QUO_W;
	localparam logic [QUO_W-1:0] Q_MID    = QUO_W'(lfps_pkg::DUTY_MID);
	localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(lfps_pkg::DUTY_MID - 1);

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             sat_q;
	logic             neg_q;
	logic             ge;
	logic [QUO_W-1:0] qf;
	logic [QUO_W-1:0] duty_w;

	assign ge = rem_q >= dsh_q;

	// Restoring division of the magnitude by a right-shifting divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsh_q  <= '0;
			q_q    <= '0;
			sat_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= num;
				dsh_q <= DIV_INIT;
				q_q   <= '0;
				sat_q <= num >= SAT_LIM;
				neg_q <= neg;
				cnt_q <= CNT_W'(QUO_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				q_q   <= {q_q[QUO_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Offset about mid scale and clamp to the duty range
	always_comb begin
		qf = sat_q ? '1 : q_q;
		if (!neg_q) begin
			duty_w = (qf > Q_POS_MAX) ? QUO_W'(16'hFFFF) : Q_MID + qf;
		end else begin
			duty_w = (qf > Q_MID) ? '0 : Q_MID - qf;
		end
	end

	assign done = done_q;
	assign duty = duty_w[lfps_pkg::DUTY_W-1:0];

endmodule

// File: sv/lfps_err_line.sv
// Delay line of recent errors with a running window sum
module lfps_err_line #(
	parameter int WINDOW = lfps_pkg::WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic signed [lfps_pkg::ERR_W-1:0]   err,
	output logic signed [lfps_pkg::ERR_W-1:0]   prev,
	output logic signed [lfps_pkg::SUM_W-1:0]   sum
);

	localparam int ERR_W = lfps_pkg::ERR_W;
	localparam int SUM_W = lfps_pkg::SUM_W;

	logic signed [ERR_W-1:0] hist_q [WINDOW];
	logic signed [SUM_W-1:0] sum_q;

	// Shift in the newest error, drop the oldest from the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				hist_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (push) begin
			hist_q[0] <= err;
			for (int i = 1; i < WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			sum_q <= sum_q + SUM_W'(err) - SUM_W'(hist_q[WINDOW-1]);
		end
	end

	assign prev = hist_q[0];
	assign sum  = sum_q;

endmodule

// File: sv/line_follow_pid_steering_unit.sv
// Line-follow PID steering unit.
// Input stream s_*: one item per control tick carrying the left, middle and
// right reflectance samples. Output stream m_*: one item per input item with
// the left and right motor duties in Q0.16, 32768 meaning stopped.
// Configuration channel cfg_*: writes the three Q8.8 gains and the signed
// power level; cfg_ready is always high, and writes are meant for idle times.
// A new item is taken only once the previous one has gone to the output
// register. Each item is worked through by the shared 4-bit digit-serial
// multiplier (seven products, one digit a cycle) and by the bit-serial divider
// that forms each duty (17 quotient bits per wheel, two wheels in turn).
// Reset clears the error history and window sum, loads the register reset
// values and empties the output register.
// A finished result waits in the output register while m_tready is low; the
// next item is taken meanwhile and computed, and it waits in the last step
// until the output register is free.
module line_follow_pid_steering_unit #(
	parameter int WINDOW = lfps_pkg::WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// left_sample [11:0], middle_sample [23:12], right_sample [35:24], zero pad
	input  logic [lfps_pkg::IN_DATA_W-1:0]        s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// left_duty [15:0], right_duty [31:16]
	output logic [lfps_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SAMPLE_W = lfps_pkg::SAMPLE_W;
	localparam int ERR_W    = lfps_pkg::ERR_W;
	localparam int DIFF_W   = lfps_pkg::DIFF_W;
	localparam int U_W      = lfps_pkg::U_W;
	localparam int A_W      = lfps_pkg::MUL_A_W;
	localparam int B_W      = lfps_pkg::MUL_B_W;
	localparam int NUM_W    = lfps_pkg::NUM_W;
	localparam int DUTY_W   = lfps_pkg::DUTY_W;
	localparam int MIDP_W   = lfps_pkg::MIDP_W;
	localparam int MTERM_W  = lfps_pkg::MTERM_W;
	localparam int EPROD_W  = lfps_pkg::EPROD_W;
	localparam int E_FRAC   = lfps_pkg::E_FRAC;
	localparam int POWER_W  = lfps_pkg::POWER_W;
	localparam logic signed [U_W-1:0] ONE = U_W'(lfps_pkg::ONE_Q24);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MID, ST_ERR, ST_PG, ST_IG, ST_DG, ST_FAC,
		ST_LMUL, ST_LDIV, ST_RDIV, ST_OUT
	} state_t;

	state_t state_q;

	logic [lfps_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [lfps_pkg::GAIN_W-1:0]  integ_gain_q;
	logic [lfps_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic signed [POWER_W-1:0]    power_q;

	logic [SAMPLE_W-1:0]          left_q;
	logic [SAMPLE_W-1:0]          right_q;
	logic signed [DIFF_W-1:0]     diff_q;
	logic signed [U_W-1:0]        lf_q;
	logic signed [U_W-1:0]        rf_q;
	logic [DUTY_W-1:0]            left_duty_q;
	logic [DUTY_W-1:0]            right_duty_q;
	logic [lfps_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                         m_tvalid_q;

	lfps_pkg::mul_cmd_t           mul_cmd;
	logic signed [A_W-1:0]        mul_a;
	logic [B_W-1:0]               mul_b;
	logic                         mul_done;
	logic signed [lfps_pkg::MUL_ACC_W-1:0] mul_acc;

	logic                         div_start;
	logic [NUM_W-1:0]             div_num;
	logic                         div_neg;
	logic                         div_done;
	logic [DUTY_W-1:0]            div_duty;

	logic                         hist_push;
	logic signed [ERR_W-1:0]      hist_prev;
	logic signed [lfps_pkg::SUM_W-1:0] hist_sum;

	logic [MIDP_W-1:0]            midp;
	logic [MTERM_W-1:0]           mterm;
	logic signed [SAMPLE_W:0]     lr_diff;
	logic signed [EPROD_W-1:0]    eprod;
	logic signed [EPROD_W-1:0]    e_rnd;
	logic signed [ERR_W-1:0]      e_new;
	logic signed [U_W-1:0]        u;
	logic [POWER_W-1:0]           pw_mag;
	logic [NUM_W-1:0]             num_rnd;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= lfps_pkg::PROP_GAIN_RST;
			integ_gain_q <= lfps_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= lfps_pkg::DERIV_GAIN_RST;
			power_q      <= lfps_pkg::POWER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfps_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				lfps_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				lfps_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				lfps_pkg::REG_POWER:      power_q      <= cfg_data[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	// Middle term, rounded error and controller output from the accumulator
	assign midp    = mul_acc[MIDP_W-1:0];
	assign mterm   = MTERM_W'(lfps_pkg::MTERM_BASE) - MTERM_W'((midp + MIDP_W'(2048)) >> E_FRAC);
	assign lr_diff = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
	assign eprod   = $signed(mul_acc[EPROD_W-1:0]);
	assign e_rnd   = eprod + (eprod[EPROD_W-1] ? EPROD_W'(2047) : EPROD_W'(2048));
	assign e_new   = $signed(e_rnd[E_FRAC +: ERR_W]);
	assign u       = $signed(mul_acc[U_W-1:0]);
	assign pw_mag  = power_q[POWER_W-1] ? POWER_W'(-power_q) : POWER_W'(power_q);
	assign num_rnd = mul_acc[NUM_W-1:0] + NUM_W'(lfps_pkg::DIV_HALF);

	// Issue multiplier and divider commands per step
	always_comb begin
		mul_cmd   = '0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = num_rnd;
		div_neg   = 1'b0;
		hist_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					mul_cmd.start = 1'b1;
					mul_cmd.ndig  = lfps_pkg::NDIG_MID;
					mul_a = A_W'(lfps_pkg::MID_COEF);
					mul_b = B_W'(s_tdata[2*SAMPLE_W-1:SAMPLE_W]);
				end
			end
			ST_MID: begin
				if (mul_done) begin
					mul_cmd.start = 1'b1;
					mul_cmd.ndig  = lfps_pkg::NDIG_MTERM;
					mul_a = A_W'(lr_diff);
					mul_b = B_W'(mterm);
				end
			end
			ST_ERR: begin
				if (mul_done) begin
					hist_push     = 1'b1;
					mul_cmd.start = 1'b1;
					mul_cmd.ndig  = lfps_pkg::NDIG_GAIN;
					mul_a = A_W'(e_new);
					mul_b = B_W'(prop_gain_q);
				end
			end
			ST_PG: begin
				if (mul_done) begin
					mul_cmd.start = 1'b1;
					mul_cmd.accum = 1'b1;
					mul_cmd.ndig  = lfps_pkg::NDIG_GAIN;
					mul_a = A_W'(hist_sum);
					mul_b = B_W'(integ_gain_q);
				end
			end
			ST_IG: begin
				if (mul_done) begin
					mul_cmd.start = 1'b1;
					mul_cmd.accum = 1'b1;
					mul_cmd.ndig  = lfps_pkg::NDIG_GAIN;
					mul_a = A_W'(diff_q);
					mul_b = B_W'(deriv_gain_q);
				end
			end
			ST_FAC: begin
				mul_cmd.start = 1'b1;
				mul_cmd.ndig  = lfps_pkg::NDIG_POWER;
				mul_a = lf_q[U_W-1] ? -lf_q : lf_q;
				mul_b = B_W'(pw_mag);
			end
			ST_LMUL: begin
				if (mul_done) begin
					div_start     = 1'b1;
					div_neg       = lf_q[U_W-1] ^ power_q[POWER_W-1];
					mul_cmd.start = 1'b1;
					mul_cmd.ndig  = lfps_pkg::NDIG_POWER;
					mul_a = rf_q[U_W-1] ? -rf_q : rf_q;
					mul_b = B_W'(pw_mag);
				end
			end
			ST_LDIV: begin
				if (div_done) begin
					div_start = 1'b1;
					div_neg   = rf_q[U_W-1] ^ power_q[POWER_W-1];
				end
			end
			default: ;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			left_q       <= '0;
			right_q      <= '0;
			diff_q       <= '0;
			lf_q         <= '0;
			rf_q         <= '0;
			left_duty_q  <= '0;
			right_duty_q <= '0;
		end else begin
			// Drop a taken item unless the next one replaces it
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						left_q  <= s_tdata[SAMPLE_W-1:0];
						right_q <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
						state_q <= ST_MID;
					end
				end
				ST_MID: begin
					if (mul_done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					if (mul_done) begin
						diff_q  <= DIFF_W'(e_new) - DIFF_W'(hist_prev);
						state_q <= ST_PG;
					end
				end
				ST_PG: begin
					if (mul_done) begin
						state_q <= ST_IG;
					end
				end
				ST_IG: begin
					if (mul_done) begin
						state_q <= ST_DG;
					end
				end
				ST_DG: begin
					if (mul_done) begin
						if (!u[U_W-1] && (u != '0)) begin
							lf_q <= ONE - u;
							rf_q <= ONE;
						end else begin
							lf_q <= ONE;
							rf_q <= ONE + u;
						end
						state_q <= ST_FAC;
					end
				end
				ST_FAC: begin
					state_q <= ST_LMUL;
				end
				ST_LMUL: begin
					if (mul_done) begin
						state_q <= ST_LDIV;
					end
				end
				ST_LDIV: begin
					if (div_done) begin
						left_duty_q <= div_duty;
						state_q     <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						right_duty_q <= div_duty;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {right_duty_q, left_duty_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lfps_digit_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.acc    (mul_acc)
	);

	lfps_duty_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.neg    (div_neg),
		.done   (div_done),
		.duty   (div_duty)
	);

	lfps_err_line #(
		.WINDOW (WINDOW)
	) u_err_line (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (hist_push),
		.err    (e_new),
		.prev   (hist_prev),
		.sum    (hist_sum)
	);

endmodule

// File: sim/tb_line_follow_pid_steering_unit.sv
`timescale 1ns / 100ps

module tb_line_follow_pid_steering_unit;

	import lfps_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int WINDOW         = WINDOW_DEF;
	localparam int PHASES         = 8;
	localparam int TICKS_PER_PHASE = 50;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 100;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// One control tick as it sits in s_tdata: left lowest
	typedef struct packed {
		logic [SAMPLE_W-1:0] right;
		logic [SAMPLE_W-1:0] middle;
		logic [SAMPLE_W-1:0] left;
	} tick_t;

	// One duty item as it sits in m_tdata: left lowest
	typedef struct packed {
		logic [DUTY_W-1:0] right;
		logic [DUTY_W-1:0] left;
	} duty_pair_t;

	typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

	// Steering predictor and store of expected duty items
	class steering_scoreboard;
		logic [GAIN_W-1:0]         kp;
		logic [GAIN_W-1:0]         ki;
		logic [GAIN_W-1:0]         kd;
		logic signed [POWER_W-1:0] power;
		logic signed [ERR_W-1:0]   err_hist [WINDOW];
		int unsigned               hist_slot;
		logic signed [SUM_W-1:0]   err_sum;
		duty_pair_t                duty_q [$];
		int unsigned               mismatches;
		int unsigned               results;

		function new();
			kp = PROP_GAIN_RST;
			ki = INTEG_GAIN_RST;
			kd = DERIV_GAIN_RST;
			power = POWER_RST;
			foreach (err_hist[i])
				err_hist[i] = '0;
			hist_slot = 0;
			err_sum = '0;
			mismatches = 0;
			results = 0;
		endfunction

		function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_PROP_GAIN:  kp = val;
				REG_INTEG_GAIN: ki = val;
				REG_DERIV_GAIN: kd = val;
				REG_POWER:      power = val[POWER_W-1:0];
				default: ;
			endcase
		endfunction

		// Nearest, ties away from zero
		function longint round_div(longint num, longint den);
			if (num < 0)
				return -((-num + den / 2) / den);
			return (num + den / 2) / den;
		endfunction

		function logic [DUTY_W-1:0] duty_of(longint factor);
			longint d;
			d = DUTY_MID + round_div(longint'(power) * factor, DIVISOR);
			if (d < 0)
				d = 0;
			if (d > 65535)
				d = 65535;
			return d[DUTY_W-1:0];
		endfunction

		function int unsigned pending();
			return duty_q.size();
		endfunction

		// Advance the error history by one tick and queue the duties it gives
		function void note_tick(tick_t t);
			longint     mterm, err, prev, oldest, u;
			longint     left_f, right_f;
			duty_pair_t want;
			mterm = MTERM_BASE - round_div(longint'(MID_COEF) * longint'(t.middle),
				longint'(1) << SAMPLE_W);
			err = round_div((longint'(t.left) - longint'(t.right)) * mterm,
				longint'(1) << SAMPLE_W);
			prev = err_hist[(hist_slot + WINDOW - 1) % WINDOW];
			oldest = err_hist[hist_slot];
			err_hist[hist_slot] = ERR_W'(err);
			hist_slot = (hist_slot + 1) % WINDOW;
			err_sum = SUM_W'(longint'(err_sum) + err - oldest);
			u = longint'(kp) * err + longint'(ki) * longint'(err_sum)
				+ longint'(kd) * (err - prev);
			// Zero steering falls to the right-wheel branch, leaving both at one
			if (u > 0) begin
				left_f = longint'(ONE_Q24) - u;
				right_f = longint'(ONE_Q24);
			end else begin
				left_f = longint'(ONE_Q24);
				right_f = longint'(ONE_Q24) + u;
			end
			want.left = duty_of(left_f);
			want.right = duty_of(right_f);
			duty_q.push_back(want);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("[%0t] MISMATCH %s", $realtime, msg);
		endtask

		task check_duties(logic [OUT_DATA_W-1:0] word);
			duty_pair_t got, want;
			got = word;
			results++;
			if (duty_q.size() == 0) begin
				report_mismatch($sformatf("item %0d: duty item %h with no tick outstanding",
					results, word));
				return;
			end
			want = duty_q.pop_front();
			if (got.left !== want.left)
				report_mismatch($sformatf("item %0d: left_duty %0d, expected %0d",
					results, got.left, want.left));
			if (got.right !== want.right)
				report_mismatch($sformatf("item %0d: right_duty %0d, expected %0d",
					results, got.right, want.right));
		endtask

		task report_leftover();
			if (duty_q.size() != 0)
				report_mismatch($sformatf("%0d ticks never produced a duty item",
					duty_q.size()));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	steering_scoreboard sb;
	int unsigned        burst_left = 0;
	bit                 long_hold_req = 1'b0;

	line_follow_pid_steering_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one tick, in bursts separated by random gaps, and note it once taken
	task automatic send_tick(input tick_t t);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(1, 6);
		end
		burst_left--;
		s_tdata <= {{(IN_DATA_W - 3 * SAMPLE_W){1'b0}}, t};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_tick(t);
	endtask

	// Stop offering and wait until every duty item has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.load_reg(idx, val);
	endtask

	// Write all four registers once the block has gone idle
	task automatic configure(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
		input logic [GAIN_W-1:0] d, input logic [POWER_W-1:0] pw);
		settle();
		put_reg(REG_PROP_GAIN, p);
		put_reg(REG_INTEG_GAIN, i);
		put_reg(REG_DERIV_GAIN, d);
		// upper byte is don't-care for the power register
		put_reg(REG_POWER, {8'($urandom), pw});
		cfg_valid <= 1'b0;
	endtask

	// Mix of free samples, near-balanced pairs and rail values
	function automatic tick_t random_tick();
		tick_t t;
		int    near;
		t.left = SAMPLE_W'($urandom);
		t.middle = SAMPLE_W'($urandom);
		t.right = SAMPLE_W'($urandom);
		case ($urandom_range(0, 3))
			1, 2: begin
				near = int'(t.left) + int'($urandom_range(0, 128)) - 64;
				if (near < 0)
					near = 0;
				if (near > int'(SAMPLE_MAX))
					near = int'(SAMPLE_MAX);
				t.right = SAMPLE_W'(near);
			end
			3: begin
				t.left = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
				t.middle = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
				t.right = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
			end
			default: ;
		endcase
		return t;
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		if ($urandom_range(0, 3) == 0)
			return GAIN_W'($urandom);
		return GAIN_W'($urandom_range(0, 600));
	endfunction

	// Stimulus: directed ticks, then random phases under changing settings
	initial begin : stimulus
		int unsigned ph;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register reset values; ticks given as {right, middle, left}
		send_tick({12'd0, 12'd0, 12'd0});
		send_tick({12'd0, 12'd0, SAMPLE_MAX});
		send_tick({12'd0, 12'd0, SAMPLE_MAX});
		send_tick({SAMPLE_MAX, 12'd0, 12'd0});
		send_tick({12'd0, SAMPLE_MAX, SAMPLE_MAX});
		send_tick({SAMPLE_MAX, SAMPLE_MAX, 12'd0});
		send_tick({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
		send_tick({12'd2048, 12'd2048, 12'd2048});
		send_tick({12'd0, 12'd0, 12'd1});
		send_tick({12'd1, 12'd0, 12'd0});
		send_tick({12'h555, 12'h555, 12'hAAA});
		send_tick({12'hAAA, 12'hAAA, 12'h555});

		// No steering, power above the nominal range
		configure(16'h0000, 16'h0000, 16'h0000, 8'h7F);
		send_tick({12'd0, 12'd0, SAMPLE_MAX});
		send_tick({12'd0, 12'd0, 12'd0});

		// Full gains and most negative power: steering far outside 0..2
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80);
		send_tick({12'd0, 12'd0, SAMPLE_MAX});
		send_tick({SAMPLE_MAX, SAMPLE_MAX, 12'd0});
		send_tick({12'd0, 12'd0, 12'd0});

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, POWER_RST);
				1: configure(16'h0000, 16'h0000, 16'h0000, 8'h7F);
				2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80);
				3: configure(random_gain(), random_gain(), random_gain(), 8'h9C);   // -100
				4: configure(random_gain(), random_gain(), random_gain(), 8'h64);   // 100
				default: configure(random_gain(), random_gain(), random_gain(),
					POWER_W'($urandom));
			endcase
			// Hold the output back while ticks keep coming so the input stalls
			if (ph == 2 || ph == 6) begin
				long_hold_req = 1'b1;
				burst_left = 12;
			end
			repeat (TICKS_PER_PHASE) send_tick(random_tick());
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.report_leftover();
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Duty item sink: check each taken item, stall in modes of its own
	initial begin : receiver
		int unsigned hold, mode_left, rx_cycle;
		ready_mode_t mode;
		hold = 0;
		mode_left = 0;
		rx_cycle = 0;
		mode = READY_ALWAYS;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_duties(m_tdata);
			rx_cycle++;
			if (mode_left == 0) begin
				mode = ready_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(100, 800);
			end else begin
				mode_left--;
			end
			if (hold != 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					READY_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
					READY_PATTERN: m_tready <= ((rx_cycle % 97) >= 61);
					default:       m_tready <= 1'b1;
				endcase
			end
		end
	end

	// Give up once nothing has moved on any channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

endmodule
